@@ rtl/core/fir_filter_circular_delay_core_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the FIR core checker
// ---------------------------------------------------------------------------
`ifndef FIR_FILTER_CIRCULAR_DELAY_CORE_MACROS_SVH
`define FIR_FILTER_CIRCULAR_DELAY_CORE_MACROS_SVH

// Property checked on every rising edge, masked while reset is held
`define FCD_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Property checked on every rising edge, reset included
`define FCD_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

@@ rtl/core/fcd_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fcd_pkg
// Shared constants and types of the circular-delay FIR core.
// ---------------------------------------------------------------------------
package fcd_pkg;

  // Filter length and derived address width
  localparam int TAPS    = 64;
  localparam int AW      = (TAPS > 1) ? $clog2(TAPS) : 1;

  // Field widths
  localparam int SMP_W   = 24;   // Q1.23 samples
  localparam int COEF_W  = 24;   // Q4.20 coefficients
  localparam int IDX_W   = 6;
  localparam int PROD_W  = SMP_W + COEF_W;
  localparam int FRAC_SH = 20;   // Q.43 -> Q.23
  localparam int ACC_W   = PROD_W + AW + 1;

  // Stream widths
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;

  // Item kinds carried on in_tuser
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COEF   = 1'b1;

  // Controls from the sequencer to the MAC
  typedef struct packed {
    logic load;   // start of a sample: preload accumulator with x
    logic vld;    // memory read data valid this cycle
    logic last;   // this read is the final tap
  } mac_ctl_t;

endpackage

@@ rtl/core/fcd_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fcd_ram
// Simple dual-port synchronous RAM, one write and one registered read.
// ---------------------------------------------------------------------------
module fcd_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 24
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
  input  logic [WIDTH-1:0]                              wr_data,
  input  logic                                          rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
  output logic [WIDTH-1:0]                              rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/fcd_mac.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fcd_mac
// Registered multiply, wide accumulate, round to Q1.23 and saturate.
// ---------------------------------------------------------------------------
module fcd_mac import fcd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctl_t                 ctl,
  input  logic signed [SMP_W-1:0]  x_in,
  input  logic signed [COEF_W-1:0] coef_in,
  input  logic signed [SMP_W-1:0]  dly_in,
  output logic                     done,
  output logic signed [SMP_W-1:0]  y_out
);

  localparam int QW = ACC_W - FRAC_SH;

  logic signed [PROD_W-1:0] mul_r;
  logic                     mul_vld_r;
  logic                     mul_last_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     done_r;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [QW-1:0]     q;
  logic                     ovf;

  // Product stage
  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      mul_r <= coef_in * dly_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r  <= 1'b0;
      mul_last_r <= 1'b0;
    end else begin
      mul_vld_r  <= ctl.vld;
      mul_last_r <= ctl.vld && ctl.last;
    end
  end

  // Accumulator: preload with x in Q.43, then add products
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc_r <= {{(ACC_W-SMP_W-FRAC_SH){x_in[SMP_W-1]}}, x_in, {FRAC_SH{1'b0}}};
    end else if (mul_vld_r) begin
      acc_r <= acc_r + ACC_W'(mul_r);
    end
  end

  // Sum complete flag, held until the next sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else if (ctl.load) begin
      done_r <= 1'b0;
    end else if (mul_vld_r && mul_last_r) begin
      done_r <= 1'b1;
    end
  end

  // Round half up, then clamp to 24 bits
  assign rnd = acc_r + (ACC_W'(1) << (FRAC_SH - 1));
  assign q   = rnd[ACC_W-1:FRAC_SH];
  assign ovf = !((&q[QW-1:SMP_W-1]) || !(|q[QW-1:SMP_W-1]));

  always_comb begin
    if (ovf) begin
      y_out = q[QW-1] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
    end else begin
      y_out = q[SMP_W-1:0];
    end
  end

  assign done = done_r;

endmodule

@@ rtl/core/fir_filter_circular_delay_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fir_filter_circular_delay_core
// 64-tap direct-form FIR with pass-through of the current sample.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream: in_tuser[0] selects the transaction kind. A sample
//   transaction (kind 0) carries sample_in; a coefficient transaction
//   (kind 1) carries tap_index and tap_value and produces no output.
//   Output stream: one filtered Q1.23 sample per sample transaction,
//   y = x + sum coef[k] * x[n-1-k], rounded and saturated.
// Timing:
//   A sample transaction reads one tap per cycle out of the coefficient
//   and delay memories, then passes through the memory read and
//   multiplier register stages. The result leaves through an output
//   register, so the next transaction is taken while it waits.
// Reset:
//   Coefficients and delay line read as zero until written, write pointer
//   at zero. No clearing pass is needed.
// Back-pressure:
//   If out_tready stays low, a finished sample waits in the sequencer and
//   in_tready stays low until the output register frees up.
// ---------------------------------------------------------------------------
module fir_filter_circular_delay_core import fcd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [23:0] sample_in, [29:24] tap_index, [53:30] tap_value, [55:54] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] mode
  input  logic [0:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [23:0] sample_out
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]               state_r, state_nxt;
  logic [AW-1:0]            k_r;
  logic [AW-1:0]            rd_r;
  logic [AW-1:0]            write_pos_r;
  logic signed [SMP_W-1:0]  x_r;
  logic [TAPS-1:0]          coef_vld_r;
  logic [TAPS-1:0]          dly_vld_r;
  logic                     coef_ok_r;
  logic                     dly_ok_r;
  logic                     rd_vld_r;
  logic                     rd_last_r;
  logic                     out_valid_r;
  logic [OUT_TDATA_W-1:0]   out_data_r;

  logic                     in_fire;
  logic                     in_mode;
  logic signed [SMP_W-1:0]  in_sample;
  logic [IDX_W-1:0]         in_idx;
  logic [COEF_W-1:0]        in_tval;
  logic                     coef_wr;
  logic                     smp_start;
  logic                     issue;
  logic                     last_tap;
  logic                     out_free;
  logic                     finish;
  logic [COEF_W-1:0]        coef_rd;
  logic [SMP_W-1:0]         dly_rd;
  logic signed [COEF_W-1:0] coef_m;
  logic signed [SMP_W-1:0]  dly_m;
  mac_ctl_t                 mac_ctl;
  logic                     mac_done;
  logic signed [SMP_W-1:0]  mac_y;

  // Field unpacking
  assign in_mode   = in_tuser[0];
  assign in_sample = in_tdata[SMP_W-1:0];
  assign in_idx    = in_tdata[SMP_W+IDX_W-1:SMP_W];
  assign in_tval   = in_tdata[SMP_W+IDX_W+COEF_W-1:SMP_W+IDX_W];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign coef_wr   = in_fire && (in_mode == MODE_COEF) && (32'(in_idx) < TAPS);
  assign smp_start = in_fire && (in_mode == MODE_SAMPLE);
  assign issue     = (state_r == ST_RUN);
  assign last_tap  = (k_r == AW'(TAPS - 1));
  assign out_free  = !out_valid_r || out_tready;
  assign finish    = (state_r == ST_DRAIN) && mac_done && out_free;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (smp_start) state_nxt = ST_RUN;
      ST_RUN:   if (last_tap)  state_nxt = ST_DRAIN;
      ST_DRAIN: if (finish)    state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Tap counter and circular read pointer (newest past sample first)
  always_ff @(posedge clk) begin
    if (smp_start) begin
      k_r  <= '0;
      rd_r <= (write_pos_r == '0) ? AW'(TAPS - 1) : write_pos_r - 1'b1;
      x_r  <= in_sample;
    end else if (issue) begin
      k_r  <= k_r + 1'b1;
      rd_r <= (rd_r == '0) ? AW'(TAPS - 1) : rd_r - 1'b1;
    end
  end

  // Write pointer advances once the sample is stored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_pos_r <= '0;
    end else if (finish) begin
      write_pos_r <= (write_pos_r == AW'(TAPS - 1)) ? '0 : write_pos_r + 1'b1;
    end
  end

  // Per-entry written flags; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0;
      dly_vld_r  <= '0;
    end else begin
      if (coef_wr) begin
        coef_vld_r[AW'(in_idx)] <= 1'b1;
      end
      if (finish) begin
        dly_vld_r[write_pos_r] <= 1'b1;
      end
    end
  end

  // Read-side tags aligned with the memory output
  always_ff @(posedge clk) begin
    if (issue) begin
      coef_ok_r <= coef_vld_r[k_r];
      dly_ok_r  <= dly_vld_r[rd_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
    end else begin
      rd_vld_r  <= issue;
      rd_last_r <= issue && last_tap;
    end
  end

  // Coefficient store
  fcd_ram #(
    .DEPTH (TAPS),
    .WIDTH (COEF_W)
  ) u_coef_ram (
    .clk     (clk),
    .wr_en   (coef_wr),
    .wr_addr (AW'(in_idx)),
    .wr_data (in_tval),
    .rd_en   (issue),
    .rd_addr (k_r),
    .rd_data (coef_rd)
  );

  // Delay line; the new sample goes in after all taps are read
  fcd_ram #(
    .DEPTH (TAPS),
    .WIDTH (SMP_W)
  ) u_dly_ram (
    .clk     (clk),
    .wr_en   (finish),
    .wr_addr (write_pos_r),
    .wr_data (x_r),
    .rd_en   (issue),
    .rd_addr (rd_r),
    .rd_data (dly_rd)
  );

  assign coef_m = coef_ok_r ? coef_rd : '0;
  assign dly_m  = dly_ok_r  ? dly_rd  : '0;

  assign mac_ctl.load = smp_start;
  assign mac_ctl.vld  = rd_vld_r;
  assign mac_ctl.last = rd_last_r;

  fcd_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mac_ctl),
    .x_in    (in_sample),
    .coef_in (coef_m),
    .dly_in  (dly_m),
    .done    (mac_done),
    .y_out   (mac_y)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r <= mac_y;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ rtl/core/fcd_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fcd_checker
// Port-level checks on the FIR core, bound to the top level.
// ---------------------------------------------------------------------------
`include "fir_filter_circular_delay_core_macros.svh"

module fcd_checker import fcd_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic [0:0]             in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // Output channel is empty right after reset
  `FCD_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_tvalid, "output valid after reset")

  // A stalled result stays offered, unchanged
  `FCD_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "result dropped")
  `FCD_ASSERT(a_out_stable, clk, rst_n,
    out_tvalid && !out_tready |=> $stable(out_tdata), "stalled result changed")

  // A sample transaction makes the core busy on the next cycle
  `FCD_ASSERT(a_busy, clk, rst_n,
    in_tvalid && in_tready && (in_tuser[0] == MODE_SAMPLE) |=> !in_tready, "not busy")

  // A new result only comes out of a busy core
  `FCD_ASSERT(a_res_src, clk, rst_n, $rose(out_tvalid) |-> !$past(in_tready), "stray result")

endmodule

bind fir_filter_circular_delay_core fcd_checker u_fcd_checker (.*);

@@ tb/fir_stream_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fir_stream_checker
// Watches both streams of the circular-delay FIR core, keeps its own copy of
// the coefficient and delay memories, predicts every filtered sample and
// compares it with the next output transaction.
// ---------------------------------------------------------------------------
module fir_stream_checker import fcd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // [23:0] sample_in, [29:24] tap_index, [53:30] tap_value, [55:54] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] mode
  input  logic [0:0]             in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // [23:0] sample_out
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     mismatch_count,
  output int                     pending_count,
  output int                     sample_count,
  output int                     coef_count,
  output int                     sat_count
);

  localparam int IDX_LO  = SMP_W;
  localparam int COEF_LO = SMP_W + IDX_W;
  localparam longint OUT_MAX = 64'sd8388607;
  localparam longint OUT_MIN = -64'sd8388608;

  // Shadow state of the filter
  logic signed [COEF_W-1:0] coef_mem [TAPS];
  logic signed [SMP_W-1:0]  history  [TAPS];
  int                       hist_pos;

  logic [SMP_W-1:0] expected_samples [$];
  int n_err;
  int n_smp;
  int n_coef;
  int n_sat;

  // y = x + sum coef[k] * x[n-1-k], rounded half up, saturated to 24 bits.
  // The new sample then goes into the delay line.
  function automatic logic [SMP_W-1:0] filter_sample(input logic signed [SMP_W-1:0] x);
    longint acc;
    longint y;
    int     rd;
    acc = longint'(x) * 64'sd1048576;
    rd  = (hist_pos == 0) ? TAPS - 1 : hist_pos - 1;
    for (int k = 0; k < TAPS; k++) begin
      acc += longint'(coef_mem[k]) * longint'(history[rd]);
      rd   = (rd == 0) ? TAPS - 1 : rd - 1;
    end
    y = (acc + 64'sd524288) >>> FRAC_SH;
    if (y > OUT_MAX) begin
      y = OUT_MAX;
      n_sat++;
    end else if (y < OUT_MIN) begin
      y = OUT_MIN;
      n_sat++;
    end
    history[hist_pos] = x;
    hist_pos = (hist_pos == TAPS - 1) ? 0 : hist_pos + 1;
    return y[SMP_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    logic [SMP_W-1:0] want;
    int               idx;
    if (!rst_n) begin
      for (int k = 0; k < TAPS; k++) begin
        coef_mem[k] = '0;
        history[k]  = '0;
      end
      hist_pos = 0;
      expected_samples.delete();
    end else begin
      // output side first: nothing accepted this edge can already be out
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          $error("sample_out: unexpected transaction, actual %0d", $signed(out_tdata));
          n_err++;
        end else begin
          want = expected_samples.pop_front();
          if (out_tdata !== want) begin
            $error("sample_out mismatch: expected %0d, actual %0d",
                   $signed(want), $signed(out_tdata));
            n_err++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == MODE_COEF) begin
          idx = int'(in_tdata[IDX_LO +: IDX_W]);
          if (idx < TAPS) coef_mem[idx] = in_tdata[COEF_LO +: COEF_W];
          n_coef++;
        end else begin
          expected_samples.push_back(filter_sample(in_tdata[SMP_W-1:0]));
          n_smp++;
        end
      end
    end
    mismatch_count <= n_err;
    pending_count  <= expected_samples.size();
    sample_count   <= n_smp;
    coef_count     <= n_coef;
    sat_count      <= n_sat;
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus for the circular-delay FIR core: directed corner transactions,
// then random sample and coefficient traffic under several idle/stall
// mixes, a long output hold-off and a drain pause. Checking is done by
// fir_stream_checker; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_top import fcd_pkg::*; ();

  localparam int     ITEMS_PER_MIX = 400;
  localparam int     HOLD_CYCLES   = 600;
  localparam int     TAIL_CYCLES   = 100;
  localparam longint CYCLE_LIMIT   = 1000000;
  localparam logic [SMP_W-1:0] S_MAX = 24'h7FFFFF;
  localparam logic [SMP_W-1:0] S_MIN = 24'h800000;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [0:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int     mismatch_count;
  int     pending_count;
  int     sample_count;
  int     coef_count;
  int     sat_count;
  int     tx_idle_pct  = 0;
  int     rx_stall_pct = 0;
  logic   hold_req     = 1'b0;
  longint cycle_count  = 0;

  always #1 clk = ~clk;

  fir_filter_circular_delay_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  fir_stream_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .sample_count   (sample_count),
    .coef_count     (coef_count),
    .sat_count      (sat_count)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Output side: random stalls, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Sample transaction: tap fields carry junk, they must be ignored
  function automatic logic [IN_TDATA_W-1:0] pack_sample(input logic [SMP_W-1:0] x);
    return {2'b00, COEF_W'($urandom), IDX_W'($urandom), x};
  endfunction

  // Coefficient transaction: sample field carries junk
  function automatic logic [IN_TDATA_W-1:0] pack_coef(input logic [IDX_W-1:0] idx,
                                                      input logic [COEF_W-1:0] val);
    return {2'b00, val, idx, SMP_W'($urandom)};
  endfunction

  function automatic logic [SMP_W-1:0] rand_sample();
    if ($urandom_range(0, 15) != 0) return SMP_W'($urandom);
    case ($urandom_range(0, 4))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      3:       return 24'h000001;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  // Mostly small coefficients so outputs are not all saturated
  function automatic logic [COEF_W-1:0] rand_coef();
    logic signed [COEF_W-1:0] v;
    v = COEF_W'($urandom);
    if ($urandom_range(0, 9) != 0) v = v >>> $urandom_range(6, 23);
    return v;
  endfunction

  task automatic send_txn(input logic kind, input logic [IN_TDATA_W-1:0] data);
    int gap;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 90) : $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic random_txn();
    if ($urandom_range(0, 99) < 15)
      send_txn(MODE_COEF, pack_coef(IDX_W'($urandom), rand_coef()));
    else
      send_txn(MODE_SAMPLE, pack_sample(rand_sample()));
  endtask

  // Stop offering and wait for every predicted result to come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = MODE_SAMPLE;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero coefficients pass x straight through
    send_txn(MODE_SAMPLE, pack_sample(S_MAX));
    send_txn(MODE_SAMPLE, pack_sample(S_MIN));
    send_txn(MODE_SAMPLE, pack_sample('0));
    // Half-LSB ties: coef[0] = 0.5, then +1 / -1 / 0 samples
    send_txn(MODE_COEF, pack_coef(6'd0, 24'h080000));
    send_txn(MODE_SAMPLE, pack_sample(24'h000001));
    send_txn(MODE_SAMPLE, pack_sample(24'hFFFFFF));
    send_txn(MODE_SAMPLE, pack_sample('0));
    // Extreme coefficients at both ends of the tap range
    send_txn(MODE_COEF, pack_coef(6'd63, S_MAX));
    send_txn(MODE_COEF, pack_coef(6'd0, S_MIN));
    send_txn(MODE_COEF, pack_coef(6'd1, S_MAX));
    send_txn(MODE_COEF, pack_coef(6'd32, 24'h000001));
    // Drive into both saturation bounds
    repeat (3) send_txn(MODE_SAMPLE, pack_sample(S_MAX));
    repeat (3) send_txn(MODE_SAMPLE, pack_sample(S_MIN));
    send_txn(MODE_SAMPLE, pack_sample(S_MAX));
    send_txn(MODE_SAMPLE, pack_sample('0));
    send_txn(MODE_COEF, pack_coef(6'd1, '0));
    send_txn(MODE_SAMPLE, pack_sample(24'h000001));
    wait_drained();

    // Random traffic under four idle/stall mixes
    for (int mix = 0; mix < 4; mix++) begin
      case (mix)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 51;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 51;
        end
        default: begin
          tx_idle_pct  = 22;
          rx_stall_pct = 22;
        end
      endcase
      repeat (ITEMS_PER_MIX) random_txn();
      wait_drained();
    end

    // Long output hold-off while samples keep coming: core must back up
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_req     = 1'b1;
    repeat (24) send_txn(MODE_SAMPLE, pack_sample(rand_sample()));
    wait_drained();
    repeat (20) random_txn();
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d sample and %0d coefficient transactions, %0d saturated outputs",
             sample_count, coef_count, sat_count);
    $display("Traffic: free-running, sender idle, receiver stall, both, long hold-off");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
